// File: rtl/core/bia_pkg.sv
// Shared constants, codes and a helper function of the block id allocator.
`timescale 1ns / 1ps

package bia_pkg;

  // Bitmap organization: one memory word covers 32 ids, one summary bit
  // covers one bitmap word.
  localparam int WORD_W  = 32;
  localparam int WORD_LW = 5;

  // Port field widths.
  localparam int OP_W   = 2;
  localparam int ID_W   = 10;
  localparam int OFF_W  = 31;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;
  localparam int BB_W   = 21;

  localparam logic [BB_W-1:0]  BB_RESET  = BB_W'(4096);
  localparam logic [OFF_W-1:0] OFF_MAX   = '1;

  // Request operations.
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DUP    = 2'd3;

  // Index of the lowest set bit of a word (zero when none is set).
  function automatic logic [WORD_LW-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [WORD_LW-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = WORD_LW'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/bia_offset.sv
// Two-stage byte offset unit: header base plus id times block size, saturated.
`timescale 1ns / 1ps

module bia_offset #(
  parameter int IdW         = 16,
  parameter int HeaderBytes = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [IdW-1:0]               id,
  input  logic [bia_pkg::BB_W-1:0]     block_bytes,
  output logic                         done,
  output logic [bia_pkg::OFF_W-1:0]    offset
);

  localparam int PW = IdW + bia_pkg::BB_W;
  localparam int SW = PW + 1;

  logic [PW-1:0]              prod_r;
  logic                       prod_vld_r;
  logic                       done_r;
  logic [bia_pkg::OFF_W-1:0]  offset_r;
  logic [SW-1:0]              sum;
  logic [bia_pkg::OFF_W-1:0]  sat;

  assign sum = SW'(prod_r) + SW'(HeaderBytes);
  assign sat = (64'(sum) > 64'(bia_pkg::OFF_MAX)) ? bia_pkg::OFF_MAX
                                                   : bia_pkg::OFF_W'(sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      prod_vld_r <= go;
      done_r     <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= PW'(id) * PW'(block_bytes);
    offset_r <= sat;
  end

  assign done   = done_r;
  assign offset = offset_r;

endmodule

// File: rtl/core/block_id_allocator_top.sv
// Top level of the block id allocator: free bitmap memories, control and result register.
`timescale 1ns / 1ps

// Channel   Ports                                         Handshake
// --------  --------------------------------------------  ---------------------------------
// config    cfg_wr_en, cfg_wr_data                        written on edge with cfg_wr_en & rst_n
// request   start, busy, in_operation, in_block_id        taken on edge with start & !busy
// result    out_valid, out_result_id, out_byte_offset,    one-cycle strobe, no back-pressure
//           out_status, out_free_count
//
// Path of each request, from accept to the next possible accept:
//   clear, invalid id, full allocate ...... answered at accept
//   allocate from the high-water mark ..... offset unit
//   locate ................................ offset unit
//   free .................................. one bitmap read-modify-write, then the offset unit
//   allocate of a freed id ................ top vector -> summary word ->
//                                           bitmap word, then the offset unit
// The offset multiply/add unit registers product, then saturated sum; result register last.
// Reset (rst_n, synchronous, active low) needs no clearing pass. A top-level
// valid vector in flip-flops marks which summary words hold live data, and a
// summary bit marks which bitmap words hold live data; a word whose valid bit
// is clear reads as all zero. Clear works the same way.
// The result side cannot stall; a result stays on the ports for one cycle
// while the next request may already be accepted.

module block_id_allocator_top #(
  parameter int BLOCK_LIMIT  = 1024,
  parameter int HEADER_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [bia_pkg::BB_W-1:0]      cfg_wr_data,
  // request
  input  logic                          start,
  output logic                          busy,
  input  logic [bia_pkg::OP_W-1:0]      in_operation,
  input  logic [bia_pkg::ID_W-1:0]      in_block_id,
  // result
  output logic                          out_valid,
  output logic [bia_pkg::ID_W-1:0]      out_result_id,
  output logic [bia_pkg::OFF_W-1:0]     out_byte_offset,
  output logic [bia_pkg::STAT_W-1:0]    out_status,
  output logic [bia_pkg::CNT_W-1:0]     out_free_count
);

  localparam int WW        = bia_pkg::WORD_W;
  localparam int WLW       = bia_pkg::WORD_LW;
  localparam int MAP_WORDS = (BLOCK_LIMIT + WW - 1) / WW;
  localparam int SUM_WORDS = (MAP_WORDS + WW - 1) / WW;
  localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int TOP_W     = 1 << SUM_AW;
  localparam int MAP_AW    = SUM_AW + WLW;
  localparam int MAP_DEPTH = 1 << MAP_AW;
  localparam int IW        = MAP_AW + WLW;   // internal id width
  localparam int CW        = $clog2(BLOCK_LIMIT + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;   // summary word on sum_q
  localparam logic [1:0] ST_MAP  = 2'd2;   // bitmap word on map_q, write back
  localparam logic [1:0] ST_OFF  = 2'd3;   // waiting on the offset unit

  // Lowest live summary word.
  function automatic logic [SUM_AW-1:0] top_first(input logic [TOP_W-1:0] v);
    logic [SUM_AW-1:0] idx;
    idx = '0;
    for (int i = TOP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = SUM_AW'(i);
    end
    return idx;
  endfunction

  // Control and bookkeeping state.
  logic [1:0]                   state_r;
  logic [bia_pkg::OP_W-1:0]     op_r;
  logic [bia_pkg::ID_W-1:0]     rid_r;
  logic [IW-1:0]                cur_id_r;
  logic [SUM_AW-1:0]            g_r;
  logic [WLW-1:0]               s_r;
  logic [bia_pkg::STAT_W-1:0]   status_r;
  logic [CW-1:0]                hw_r;
  logic [CW-1:0]                ft_r;
  logic [TOP_W-1:0]             top_r;
  logic [bia_pkg::BB_W-1:0]     bb_r;
  logic                         off_go_r;
  logic                         off_go_nxt;

  // Result register.
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [bia_pkg::ID_W-1:0]     out_rid_r;
  logic [bia_pkg::OFF_W-1:0]    out_off_r;
  logic [bia_pkg::STAT_W-1:0]   out_stat_r;
  logic [bia_pkg::CNT_W-1:0]    out_cnt_r;

  // Memories: summary words and bitmap words.
  logic [WW-1:0]                sum_mem [TOP_W];
  logic [WW-1:0]                map_mem [MAP_DEPTH];
  logic [WW-1:0]                sum_q;
  logic [WW-1:0]                map_q;
  logic [SUM_AW-1:0]            sum_raddr;
  logic [MAP_AW-1:0]            map_raddr;
  logic                         mem_we;
  logic [WW-1:0]                sum_wdata;
  logic [WW-1:0]                map_wdata;

  // Request decode.
  logic                         accept;
  logic                         op_alloc;
  logic [IW-1:0]                id_ext;
  logic [SUM_AW-1:0]            id_g;
  logic [WLW-1:0]               id_s;
  logic                         id_ok;
  logic                         hw_room;
  logic [SUM_AW-1:0]            top_g;

  // Read-modify-write of one bitmap word.
  logic                         word_live;
  logic [WW-1:0]                sum_eff;
  logic [WW-1:0]                map_eff;
  logic [WLW-1:0]               bit_sel;
  logic                         dup;
  logic [WW-1:0]                map_clr;
  logic [WW-1:0]                sum_clr;

  // Offset unit.
  logic                         off_done;
  logic [bia_pkg::OFF_W-1:0]    off_data;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign op_alloc = (in_operation == bia_pkg::OP_ALLOC);
  assign id_ext   = IW'(in_block_id);
  assign id_g     = id_ext[IW-1 -: SUM_AW];
  assign id_s     = id_ext[2*WLW-1:WLW];
  assign id_ok    = (32'(in_block_id) < 32'(hw_r));
  assign hw_room  = (32'(hw_r) < 32'(BLOCK_LIMIT));
  assign top_g    = top_first(top_r);

  // Offset start: a mark allocate or a valid locate at accept, or any
  // request leaving the bitmap stage.
  assign off_go_nxt = (accept && op_alloc && (ft_r == '0) && hw_room)
                   || (accept && (in_operation == bia_pkg::OP_LOCATE) && id_ok)
                   || (state_r == ST_MAP);

  // Result strobe: immediate answers at accept, or the offset coming back.
  assign out_valid_nxt = (accept && op_alloc && (ft_r == '0) && !hw_room)
                      || (accept && !op_alloc && (in_operation != bia_pkg::OP_CLEAR)
                          && !id_ok)
                      || (accept && (in_operation == bia_pkg::OP_CLEAR))
                      || ((state_r == ST_OFF) && off_done);

  // Summary read address holds on g_r once the request is in flight.
  always_comb begin
    if (state_r == ST_IDLE) begin
      sum_raddr = op_alloc ? top_g : id_g;
    end else begin
      sum_raddr = g_r;
    end
    if (state_r == ST_SUM) begin
      map_raddr = {g_r, bia_pkg::first_set(sum_q)};
    end else begin
      map_raddr = id_ext[IW-1:WLW];
    end
  end

  // Stale memory contents behind a clear valid bit read as zero.
  always_comb begin
    word_live = top_r[g_r] && sum_q[s_r];
    sum_eff   = top_r[g_r] ? sum_q : '0;
    map_eff   = word_live ? map_q : '0;
    bit_sel   = (op_r == bia_pkg::OP_ALLOC) ? bia_pkg::first_set(map_eff)
                                             : cur_id_r[WLW-1:0];
    dup       = map_eff[bit_sel];
    map_clr   = map_eff & ~(WW'(1) << bit_sel);
    sum_clr   = (map_clr == '0) ? (sum_eff & ~(WW'(1) << s_r)) : sum_eff;
    mem_we    = 1'b0;
    sum_wdata = sum_clr;
    map_wdata = map_clr;
    if (state_r == ST_MAP) begin
      if (op_r == bia_pkg::OP_ALLOC) begin
        mem_we = 1'b1;
      end else begin
        mem_we    = !dup;
        map_wdata = map_eff | (WW'(1) << bit_sel);
        sum_wdata = sum_eff | (WW'(1) << s_r);
      end
    end
  end

  // Requests are handled one at a time, so a write-back always lands before
  // the next request issues its reads; no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[g_r]        <= sum_wdata;
      map_mem[{g_r, s_r}] <= map_wdata;
    end
    sum_q <= sum_mem[sum_raddr];
    map_q <= map_mem[map_raddr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r <= bia_pkg::BB_RESET;
    end else if (cfg_wr_en) begin
      bb_r <= cfg_wr_data;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hw_r        <= '0;
      ft_r        <= '0;
      top_r       <= '0;
      off_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= bia_pkg::OP_ALLOC;
    end else begin
      off_go_r    <= off_go_nxt;
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= in_operation;
            // mark allocates take the mark; freed allocates fill these in later
            rid_r    <= op_alloc ? bia_pkg::ID_W'(hw_r) : in_block_id;
            cur_id_r <= op_alloc ? IW'(hw_r) : id_ext;
            g_r      <= op_alloc ? top_g : id_g;
            s_r      <= id_s;
            status_r <= bia_pkg::STAT_OK;
            unique case (in_operation) inside
              bia_pkg::OP_ALLOC: begin
                if (ft_r != '0) begin
                  state_r <= ST_SUM;
                end else if (hw_room) begin
                  hw_r    <= hw_r + CW'(1);
                  state_r <= ST_OFF;
                end else begin
                  out_rid_r  <= '0;
                  out_off_r  <= '0;
                  out_stat_r <= bia_pkg::STAT_FULL;
                  out_cnt_r  <= bia_pkg::CNT_W'(ft_r);
                end
              end
              bia_pkg::OP_FREE, bia_pkg::OP_LOCATE: begin
                if (!id_ok) begin
                  out_rid_r  <= in_block_id;
                  out_off_r  <= '0;
                  out_stat_r <= bia_pkg::STAT_BAD_ID;
                  out_cnt_r  <= bia_pkg::CNT_W'(ft_r);
                end else if (in_operation == bia_pkg::OP_FREE) begin
                  state_r <= ST_MAP;
                end else begin
                  state_r <= ST_OFF;
                end
              end
              bia_pkg::OP_CLEAR: begin
                hw_r       <= '0;
                ft_r       <= '0;
                top_r      <= '0;
                out_rid_r  <= '0;
                out_off_r  <= '0;
                out_stat_r <= bia_pkg::STAT_OK;
                out_cnt_r  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SUM: begin
          s_r     <= bia_pkg::first_set(sum_q);
          state_r <= ST_MAP;
        end
        ST_MAP: begin
          if (op_r == bia_pkg::OP_ALLOC) begin
            cur_id_r <= {g_r, s_r, bit_sel};
            rid_r    <= bia_pkg::ID_W'({g_r, s_r, bit_sel});
            ft_r     <= ft_r - CW'(1);
            if (sum_clr == '0) top_r[g_r] <= 1'b0;
          end else if (dup) begin
            status_r <= bia_pkg::STAT_DUP;
          end else begin
            ft_r       <= ft_r + CW'(1);
            top_r[g_r] <= 1'b1;
          end
          state_r <= ST_OFF;
        end
        ST_OFF: begin
          if (off_done) begin
            out_rid_r  <= rid_r;
            out_off_r  <= off_data;
            out_stat_r <= status_r;
            out_cnt_r  <= bia_pkg::CNT_W'(ft_r);
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  bia_offset #(
    .IdW         (IW),
    .HeaderBytes (HEADER_BYTES)
  ) u_offset (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (off_go_r),
    .id          (cur_id_r),
    .block_bytes (bb_r),
    .done        (off_done),
    .offset      (off_data)
  );

  assign out_valid       = out_valid_r;
  assign out_result_id   = out_rid_r;
  assign out_byte_offset = out_off_r;
  assign out_status      = out_stat_r;
  assign out_free_count  = out_cnt_r;

  // Freed ids are always ids that were handed out.
  a_free_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
    ft_r <= hw_r)
    else $error("free count above high-water mark");

  // A nonzero free count needs a live summary word to search.
  a_free_has_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (ft_r != '0) |-> (top_r != '0))
    else $error("free ids with no live summary word");

  // An accepted request either answers at once or occupies the sequencer.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request dropped");

  // Repeat-free status comes only from a free request.
  a_dup_from_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bia_pkg::STAT_DUP) |-> (op_r == bia_pkg::OP_FREE))
    else $error("repeat-free status on a non-free request");

  // The offset unit only finishes while the sequencer waits on it.
  a_offset_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    off_done |-> (state_r == ST_OFF))
    else $error("offset result outside its wait state");

endmodule
